[rtl/pipc_pkg.sv]
// ----------------------------------------------------------------------------
// pipc_pkg: shared definitions for the point-in-polygon collider
// Widths, limits, operation codes, status codes and register indices used by the block.
// ----------------------------------------------------------------------------
package pipc_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned ProdW  = 2 * DiffW;
  localparam int unsigned BoundW = 50;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned CntW   = AddrW + 1;
  localparam int unsigned MemW   = 2 * CoordW;

  localparam logic [CntW-1:0] MaxVertices = CntW'(64);
  localparam logic [CntW-1:0] MinKeep     = CntW'(3);

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_HIT    = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BADIDX = 2'd1;
  localparam logic [1:0] ST_FEW    = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_FLOOR_Z  = 2'd2;
  localparam logic [1:0] CFG_CEIL_Z   = 2'd3;

endpackage

[rtl/point_in_polygon_collider.sv]
// ----------------------------------------------------------------------------
// point_in_polygon_collider
// Vertex table with edit operations and an even-odd point-in-polygon test.
// ----------------------------------------------------------------------------
// Usage: one beat on the slave stream carries an operation in tuser and the
// index and x, y, z position in tdata. Each beat produces exactly one beat on
// the master stream with status, hit and the vertex count. Registers for the
// centre, floor and ceiling are written through the cfg channel, by the user
// only while idle; the block itself does not enforce it. Vertices live in a
// 64 x 48 bit synchronous RAM with one write and one read port. Every pass
// over the table goes through one RAM read per cycle and a three-stage
// difference / multiply / compare pipeline. Rejected items go straight to
// the result; append and insert feed only the new point, overwrite, remove
// and hit tests walk the whole table, and insert and remove first shift the
// rest of it. The next beat is taken at the earliest in the cycle after the
// previous result is in the output register, so a stalled master side holds
// one result and blocks a second one only when that is finished too. Reset
// empties the table, clears the bound and loads the register defaults; no
// RAM clearing pass is needed since only entries below the count are read.
// ----------------------------------------------------------------------------
module point_in_polygon_collider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // index[6:0], pos_x, pos_y, pos_z, zero pad
  input  logic [2:0]  s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // status[1:0], hit, vertex_count, zero pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT, S_GAP, S_INS, S_FEEDPT, S_SEED, S_WALK, S_DRAIN, S_DONE
  } state_e;

  typedef enum logic [1:0] {K_GROW, K_CHECK, K_EDGE, K_SEED} kind_e;

  localparam int unsigned CW = pipc_pkg::CoordW;
  localparam int unsigned DW = pipc_pkg::DiffW;
  localparam int unsigned PW = pipc_pkg::ProdW;
  localparam int unsigned BW = pipc_pkg::BoundW;
  localparam int unsigned AW = pipc_pkg::AddrW;
  localparam int unsigned NW = pipc_pkg::CntW;
  localparam int unsigned MW = pipc_pkg::MemW;

  // Configuration registers
  logic signed [CW-1:0] cx_q, cy_q, fz_q, cz_q;

  // Control
  state_e          state_q;
  logic [2:0]      op_q;
  logic [NW-1:0]   idx_q;
  logic signed [CW-1:0] px_q, py_q;
  logic [NW-1:0]   count_q;
  logic [BW-1:0]   bound_q;
  logic [1:0]      status_q;
  logic [NW-1:0]   k_q, end_q;
  logic            up_q;
  logic [AW-1:0]   walk_q;
  logic            inside_q, outside_q;
  logic            m_valid_q;
  logic [15:0]     m_data_q;

  // RAM
  logic [MW-1:0]   vmem [2**AW];
  logic [MW-1:0]   rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [MW-1:0]   mem_wdata;
  logic            wr_pend_q;
  logic [AW-1:0]   wr_addr_q;

  // Pipeline
  logic            s0_v_q, s0_mem_q;
  kind_e           s0_kind_q;
  logic            a_v_q, a_cond_q;
  kind_e           a_kind_q;
  logic signed [DW-1:0] a_o1_q, a_o2_q, a_o3_q, a_o4_q;
  logic            b_v_q, b_cond_q, b_dpos_q, b_dneg_q;
  kind_e           b_kind_q;
  logic signed [PW-1:0] b_p1_q, b_p2_q;
  logic signed [CW-1:0] prev_x_q, prev_y_q;
  logic            busy;

  // Input fields
  logic                 acc;
  logic [2:0]           op_in;
  logic [NW-1:0]        idx_in;
  logic signed [CW-1:0] px_in, py_in, pz_in;
  logic [NW-1:0]        cnt_m1;

  // Decode of an accepted beat
  state_e          dec_state;
  logic [1:0]      dec_status;
  logic            dec_wr, dec_inc, dec_dec, dec_clr;
  logic [AW-1:0]   dec_waddr;

  assign op_in  = s_axis_tuser;
  assign idx_in = s_axis_tdata[6:0];
  assign px_in  = s_axis_tdata[30:7];
  assign py_in  = s_axis_tdata[54:31];
  assign pz_in  = s_axis_tdata[78:55];
  assign cnt_m1 = count_q - NW'(1);
  assign busy   = s0_v_q | a_v_q | b_v_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign acc           = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    dec_state  = S_DONE;
    dec_status = pipc_pkg::ST_DONE;
    dec_wr     = 1'b0;
    dec_inc    = 1'b0;
    dec_dec    = 1'b0;
    dec_clr    = 1'b0;
    dec_waddr  = count_q[AW-1:0];
    case (op_in)
      pipc_pkg::OP_APPEND: begin
        if (count_q >= pipc_pkg::MaxVertices) begin
          dec_status = pipc_pkg::ST_FULL;
        end else begin
          dec_wr    = 1'b1;
          dec_inc   = 1'b1;
          dec_state = S_FEEDPT;
        end
      end
      pipc_pkg::OP_INSERT: begin
        if (idx_in > count_q) begin
          dec_status = pipc_pkg::ST_BADIDX;
        end else if (count_q >= pipc_pkg::MaxVertices) begin
          dec_status = pipc_pkg::ST_FULL;
        end else if (idx_in == count_q) begin
          dec_wr    = 1'b1;
          dec_inc   = 1'b1;
          dec_state = S_FEEDPT;
        end else begin
          dec_state = S_SHIFT;
        end
      end
      pipc_pkg::OP_REMOVE: begin
        if (count_q <= pipc_pkg::MinKeep) begin
          dec_status = pipc_pkg::ST_FEW;
        end else if (idx_in >= count_q) begin
          dec_status = pipc_pkg::ST_BADIDX;
        end else begin
          dec_dec   = 1'b1;
          dec_clr   = 1'b1;
          dec_state = (idx_in == cnt_m1) ? S_WALK : S_SHIFT;
        end
      end
      pipc_pkg::OP_WRITE: begin
        if (idx_in >= count_q) begin
          dec_status = pipc_pkg::ST_BADIDX;
        end else begin
          dec_wr    = 1'b1;
          dec_waddr = idx_in[AW-1:0];
          dec_clr   = 1'b1;
          dec_state = S_WALK;
        end
      end
      pipc_pkg::OP_HIT: begin
        if (count_q != '0 && pz_in <= cz_q && pz_in >= fz_q) begin
          dec_state = S_FEEDPT;
        end
      end
      default: dec_state = S_DONE;
    endcase
  end

  // RAM ports; the sources never coincide by construction of the sequence.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dec_waddr;
    mem_wdata = {px_in, py_in};
    if (acc && dec_wr) begin
      mem_we = 1'b1;
    end else if (wr_pend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr_q;
      mem_wdata = rdata_q;
    end else if (state_q == S_INS) begin
      mem_we    = 1'b1;
      mem_waddr = idx_q[AW-1:0];
      mem_wdata = {px_q, py_q};
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = walk_q;
    case (state_q)
      S_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = up_q ? AW'(k_q - NW'(1)) : AW'(k_q + NW'(1));
      end
      S_SEED: begin
        mem_re    = 1'b1;
        mem_raddr = cnt_m1[AW-1:0];
      end
      S_WALK: mem_re = 1'b1;
      default: mem_re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= vmem[mem_raddr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      fz_q <= {1'b1, {(CW-1){1'b0}}};
      cz_q <= {1'b0, {(CW-1){1'b1}}};
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pipc_pkg::CFG_CENTER_X: cx_q <= cfg_data_i;
        pipc_pkg::CFG_CENTER_Y: cy_q <= cfg_data_i;
        pipc_pkg::CFG_FLOOR_Z:  fz_q <= cfg_data_i;
        pipc_pkg::CFG_CEIL_Z:   cz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= pipc_pkg::OP_APPEND;
      idx_q     <= '0;
      px_q      <= '0;
      py_q      <= '0;
      count_q   <= '0;
      status_q  <= pipc_pkg::ST_DONE;
      k_q       <= '0;
      end_q     <= '0;
      up_q      <= 1'b0;
      walk_q    <= '0;
      wr_pend_q <= 1'b0;
      wr_addr_q <= '0;
      s0_v_q    <= 1'b0;
      s0_mem_q  <= 1'b0;
      s0_kind_q <= K_GROW;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      wr_pend_q <= 1'b0;
      s0_v_q    <= 1'b0;
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            state_q  <= dec_state;
            op_q     <= op_in;
            idx_q    <= idx_in;
            px_q     <= px_in;
            py_q     <= py_in;
            status_q <= dec_status;
            walk_q   <= '0;
            if (dec_inc) count_q <= count_q + NW'(1);
            if (dec_dec) count_q <= cnt_m1;
            up_q     <= (op_in == pipc_pkg::OP_INSERT);
            if (op_in == pipc_pkg::OP_INSERT) begin
              k_q   <= count_q;
              end_q <= idx_in + NW'(1);
            end else begin
              k_q   <= idx_in;
              end_q <= count_q - NW'(2);
            end
          end
        end
        S_SHIFT: begin
          wr_pend_q <= 1'b1;
          wr_addr_q <= k_q[AW-1:0];
          if (k_q == end_q) begin
            state_q <= S_GAP;
          end else begin
            k_q <= up_q ? k_q - NW'(1) : k_q + NW'(1);
          end
        end
        S_GAP: state_q <= up_q ? S_INS : S_WALK;
        S_INS: begin
          count_q <= count_q + NW'(1);
          state_q <= S_FEEDPT;
        end
        S_FEEDPT: begin
          s0_v_q    <= 1'b1;
          s0_mem_q  <= 1'b0;
          s0_kind_q <= (op_q == pipc_pkg::OP_HIT) ? K_CHECK : K_GROW;
          state_q   <= (op_q == pipc_pkg::OP_HIT) ? S_SEED : S_DRAIN;
        end
        S_SEED: begin
          s0_v_q    <= 1'b1;
          s0_mem_q  <= 1'b1;
          s0_kind_q <= K_SEED;
          state_q   <= S_WALK;
        end
        S_WALK: begin
          s0_v_q    <= 1'b1;
          s0_mem_q  <= 1'b1;
          s0_kind_q <= (op_q == pipc_pkg::OP_HIT) ? K_EDGE : K_GROW;
          if (walk_q == cnt_m1[AW-1:0]) begin
            state_q <= S_DRAIN;
          end else begin
            walk_q <= walk_q + AW'(1);
          end
        end
        S_DRAIN: begin
          if (!busy) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, count_q,
                          (op_q == pipc_pkg::OP_HIT) && inside_q && !outside_q,
                          status_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Stage A: differences against the centre, or the edge terms.
  logic signed [CW-1:0] vx, vy;
  logic signed [DW-1:0] d1, d2, d3, d4;
  logic                 cond;

  assign vx = s0_mem_q ? rdata_q[MW-1:CW] : px_q;
  assign vy = s0_mem_q ? rdata_q[CW-1:0]  : py_q;

  always_comb begin
    cond = (vy < py_q && prev_y_q >= py_q) || (prev_y_q < py_q && vy >= py_q);
    if (s0_kind_q == K_EDGE) begin
      d1 = DW'(py_q) - DW'(vy);
      d2 = DW'(prev_x_q) - DW'(vx);
      d3 = DW'(px_q) - DW'(vx);
      d4 = DW'(prev_y_q) - DW'(vy);
    end else begin
      d1 = DW'(vx) - DW'(cx_q);
      d2 = d1;
      d3 = DW'(vy) - DW'(cy_q);
      d4 = d3;
    end
  end

  // Stage C inputs
  logic [BW-1:0] sum;
  assign sum = BW'(b_p1_q) + BW'(b_p2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q     <= 1'b0;
      b_v_q     <= 1'b0;
      a_kind_q  <= K_GROW;
      b_kind_q  <= K_GROW;
      bound_q   <= '0;
      inside_q  <= 1'b0;
      outside_q <= 1'b0;
    end else begin
      a_v_q    <= s0_v_q && (s0_kind_q != K_SEED);
      a_kind_q <= s0_kind_q;
      b_v_q    <= a_v_q;
      b_kind_q <= a_kind_q;
      if (acc) begin
        inside_q  <= 1'b0;
        outside_q <= 1'b0;
        if (dec_clr) bound_q <= '0;
      end else if (b_v_q) begin
        case (b_kind_q)
          K_GROW:  if (sum > bound_q) bound_q <= sum;
          K_CHECK: outside_q <= (sum > bound_q);
          K_EDGE: begin
            if (b_cond_q && ((b_dpos_q && b_p1_q < b_p2_q) ||
                             (b_dneg_q && b_p1_q > b_p2_q))) begin
              inside_q <= ~inside_q;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (s0_v_q && (s0_kind_q == K_SEED || s0_kind_q == K_EDGE)) begin
      prev_x_q <= vx;
      prev_y_q <= vy;
    end
    a_o1_q   <= d1;
    a_o2_q   <= d2;
    a_o3_q   <= d3;
    a_o4_q   <= d4;
    a_cond_q <= cond;
    b_p1_q   <= a_o1_q * a_o2_q;
    b_p2_q   <= a_o3_q * a_o4_q;
    b_cond_q <= a_cond_q;
    b_dpos_q <= (a_o4_q > 0);
    b_dneg_q <= (a_o4_q < 0);
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pipc_pkg::MaxVertices) else $error("vertex count above limit");
  a_walk_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> !mem_we) else $error("RAM write during table walk");
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !busy) else $error("pipeline busy while taking a beat");
  a_shift_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |=> wr_pend_q) else $error("shift read without write back");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: point-in-polygon collider testbench
// Directed table of edge cases, then random vertex edits and hit tests, all
// checked beat by beat against a behavioral model or a typed outcome.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned IdleLimit = 20000;

  // Field order matches the result tdata, lowest bits last.
  typedef struct packed {
    logic [6:0] count;
    logic       hit;
    logic [1:0] status;
  } outcome_t;

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  idx;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    bit          typed;
    outcome_t    want;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  point_in_polygon_collider i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state.
  longint vx[64], vy[64];
  int     held;
  longint bound;
  longint cx, cy, fz, cz;

  outcome_t outcome_q[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  busy_free = 1'b0;

  function automatic longint dist_sq(longint x, longint y);
    longint dx, dy;
    dx = x - cx;
    dy = y - cy;
    return dx * dx + dy * dy;
  endfunction

  function automatic void rebuild_bound();
    longint d;
    bound = 0;
    for (int i = 0; i < held; i++) begin
      d = dist_sq(vx[i], vy[i]);
      if (d > bound) bound = d;
    end
  endfunction

  // Crossing-number test; products fit in 64-bit signed (below 2^52).
  function automatic bit point_inside(longint x, longint y, longint z);
    bit in;
    int j;
    longint d, lhs, rhs;
    in = 1'b0;
    if (dist_sq(x, y) > bound) return 1'b0;
    if (z > cz || z < fz) return 1'b0;
    if (held == 0) return 1'b0;
    j = held - 1;
    for (int i = 0; i < held; i++) begin
      if ((vy[i] < y && vy[j] >= y) || (vy[j] < y && vy[i] >= y)) begin
        d = vy[j] - vy[i];
        lhs = (y - vy[i]) * (vx[j] - vx[i]);
        rhs = (x - vx[i]) * d;
        if ((d > 0 && lhs < rhs) || (d < 0 && lhs > rhs)) in = !in;
      end
      j = i;
    end
    return in;
  endfunction

  function automatic outcome_t apply_edit(row_t r);
    outcome_t o;
    longint x, y, d;
    x = longint'(signed'(r.x));
    y = longint'(signed'(r.y));
    o = '0;
    case (r.op)
      pipc_pkg::OP_APPEND: begin
        if (held >= 64) o.status = pipc_pkg::ST_FULL;
        else begin
          vx[held] = x;
          vy[held] = y;
          held++;
          d = dist_sq(x, y);
          if (d > bound) bound = d;
        end
      end
      pipc_pkg::OP_INSERT: begin
        if (r.idx > held) o.status = pipc_pkg::ST_BADIDX;
        else if (held >= 64) o.status = pipc_pkg::ST_FULL;
        else begin
          for (int k = held; k > r.idx; k--) begin
            vx[k] = vx[k-1];
            vy[k] = vy[k-1];
          end
          vx[r.idx] = x;
          vy[r.idx] = y;
          held++;
          d = dist_sq(x, y);
          if (d > bound) bound = d;
        end
      end
      pipc_pkg::OP_REMOVE: begin
        if (held <= 3) o.status = pipc_pkg::ST_FEW;
        else if (r.idx >= held) o.status = pipc_pkg::ST_BADIDX;
        else begin
          for (int k = r.idx; k + 1 < held; k++) begin
            vx[k] = vx[k+1];
            vy[k] = vy[k+1];
          end
          held--;
          rebuild_bound();
        end
      end
      pipc_pkg::OP_WRITE: begin
        if (r.idx >= held) o.status = pipc_pkg::ST_BADIDX;
        else begin
          vx[r.idx] = x;
          vy[r.idx] = y;
          rebuild_bound();
        end
      end
      pipc_pkg::OP_HIT: o.hit = point_inside(x, y, longint'(signed'(r.z)));
      default: ;
    endcase
    o.count = 7'(held);
    return o;
  endfunction

  // The model is stepped for every row; a typed row is checked against its
  // typed outcome instead of the model's.
  task automatic send_beat(row_t r);
    outcome_t o;
    while ($urandom_range(99) < 19 && !busy_free) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    o = apply_edit(r);
    if (r.typed) o = r.want;
    outcome_q = {outcome_q, o};
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {8'h00, r.z, r.y, r.x, r.idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      pipc_pkg::CFG_CENTER_X: cx = longint'(signed'(val));
      pipc_pkg::CFG_CENTER_Y: cy = longint'(signed'(val));
      pipc_pkg::CFG_FLOOR_Z:  fz = longint'(signed'(val));
      default:                cz = longint'(signed'(val));
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic row_t make_row(logic [2:0] op, logic [6:0] idx, logic [23:0] x,
                                    logic [23:0] y, logic [23:0] z);
    row_t r;
    r.op = op; r.idx = idx; r.x = x; r.y = y; r.z = z;
    r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(logic [2:0] op, logic [6:0] idx, logic [1:0] st,
                                     logic [6:0] cnt);
    row_t r;
    r = make_row(op, idx, '0, '0, '0);
    r.typed = 1'b1;
    r.want = '{count: cnt, hit: 1'b0, status: st};
    return r;
  endfunction

  // Random coordinate: mostly near a small square, sometimes full range.
  function automatic logic [23:0] rand_coord();
    if ($urandom_range(9) == 0) return 24'($urandom);
    return 24'($signed($urandom_range(8000)) - 4000);
  endfunction

  function automatic row_t rand_row();
    int pick;
    logic [2:0] op;
    logic [6:0] idx;
    pick = $urandom_range(99);
    if (pick < 45) op = pipc_pkg::OP_HIT;
    else if (pick < 60) op = pipc_pkg::OP_APPEND;
    else if (pick < 72) op = pipc_pkg::OP_INSERT;
    else if (pick < 86) op = pipc_pkg::OP_REMOVE;
    else if (pick < 97) op = pipc_pkg::OP_WRITE;
    else op = 3'($urandom_range(7, 5));
    if ($urandom_range(15) == 0) idx = 7'($urandom);
    else idx = 7'($urandom_range(held));
    // Keep the table size wandering rather than pinned full or empty.
    if (held > 40 && op == pipc_pkg::OP_APPEND && $urandom_range(1)) op = pipc_pkg::OP_REMOVE;
    return make_row(op, idx, rand_coord(), rand_coord(),
                    $urandom_range(3) == 0 ? 24'($urandom) : rand_coord());
  endfunction

  // Result side: random stalls, then compare each beat.
  always @(posedge clk_i) begin
    outcome_t got, exp;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[9:0];
      if (outcome_q.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        exp = outcome_q.pop_front();
        if (got.status !== exp.status) begin
          $error("status exp %0d got %0d", exp.status, got.status); errors++;
        end
        if (got.hit !== exp.hit) begin
          $error("hit exp %0d got %0d", exp.hit, got.hit); errors++;
        end
        if (got.count !== exp.count) begin
          $error("vertex_count exp %0d got %0d", exp.count, got.count); errors++;
        end
      end
    end
    if (rst_ni) m_axis_tready <= busy_free || ($urandom_range(99) >= 19);
  end

  // Watchdog on accepted beats of any kind.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    row_t tbl[$];
    held = 0; bound = 0; cx = 0; cy = 0;
    fz = -64'sd8388608; cz = 64'sd8388607;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: rejects on an empty table, then a square and probes.
    tbl = {tbl, typed_row(pipc_pkg::OP_HIT, 7'd0, pipc_pkg::ST_DONE, 7'd0)};
    tbl = {tbl, typed_row(pipc_pkg::OP_REMOVE, 7'd0, pipc_pkg::ST_FEW, 7'd0)};
    tbl = {tbl, typed_row(pipc_pkg::OP_WRITE, 7'd0, pipc_pkg::ST_BADIDX, 7'd0)};
    tbl = {tbl, typed_row(pipc_pkg::OP_INSERT, 7'd1, pipc_pkg::ST_BADIDX, 7'd0)};
    tbl = {tbl, typed_row(3'd7, 7'd127, pipc_pkg::ST_DONE, 7'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_APPEND, 7'd0, -24'sd1000, -24'sd1000, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_APPEND, 7'd0, 24'sd1000, -24'sd1000, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_APPEND, 7'd0, 24'sd1000, 24'sd1000, 24'd0)};
    tbl = {tbl, typed_row(pipc_pkg::OP_REMOVE, 7'd0, pipc_pkg::ST_FEW, 7'd3)};
    tbl = {tbl, make_row(pipc_pkg::OP_INSERT, 7'd3, -24'sd1000, 24'sd1000, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_HIT, 7'd0, 24'd0, 24'd0, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_HIT, 7'd0, 24'sd1000, 24'd0, 24'h800000)};
    tbl = {tbl, make_row(pipc_pkg::OP_HIT, 7'd0, -24'sd1000, 24'sd500, 24'h7fffff)};
    tbl = {tbl, make_row(pipc_pkg::OP_HIT, 7'd0, 24'sd2000, 24'd0, 24'd0)};
    tbl = {tbl, typed_row(pipc_pkg::OP_REMOVE, 7'd4, pipc_pkg::ST_BADIDX, 7'd4)};
    tbl = {tbl, typed_row(pipc_pkg::OP_WRITE, 7'd127, pipc_pkg::ST_BADIDX, 7'd4)};
    tbl = {tbl, make_row(pipc_pkg::OP_WRITE, 7'd0, 24'h800000, 24'h7fffff, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_HIT, 7'd0, 24'h7fffff, 24'h800000, 24'h7fffff)};
    tbl = {tbl, make_row(pipc_pkg::OP_REMOVE, 7'd0, 24'd0, 24'd0, 24'd0)};
    tbl = {tbl, make_row(pipc_pkg::OP_INSERT, 7'd0, 24'h7fffff, 24'h800000, 24'd0)};
    foreach (tbl[i]) send_beat(tbl[i]);
    // Fill the table to trigger the full rejects.
    while (held < 64)
      send_beat(make_row(pipc_pkg::OP_APPEND, 7'd0, rand_coord(), rand_coord(), 24'd0));
    send_beat(typed_row(pipc_pkg::OP_APPEND, 7'd0, pipc_pkg::ST_FULL, 7'd64));
    send_beat(typed_row(pipc_pkg::OP_INSERT, 7'd64, pipc_pkg::ST_FULL, 7'd64));
    send_beat(typed_row(pipc_pkg::OP_INSERT, 7'd65, pipc_pkg::ST_BADIDX, 7'd64));
    send_beat(make_row(pipc_pkg::OP_HIT, 7'd0, 24'd0, 24'd0, 24'd0));
    drain();
    while (held > 4)
      send_beat(make_row(pipc_pkg::OP_REMOVE, 7'($urandom_range(held - 1)),
                         24'd0, 24'd0, 24'd0));
    drain();

    // Random phases with changing register settings, extremes first.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(pipc_pkg::CFG_CENTER_X, 24'h800000);
          write_reg(pipc_pkg::CFG_CENTER_Y, 24'h7fffff);
          write_reg(pipc_pkg::CFG_FLOOR_Z, 24'h7fffff);
          write_reg(pipc_pkg::CFG_CEIL_Z, 24'h800000);
        end
        1: begin
          write_reg(pipc_pkg::CFG_CENTER_X, 24'h7fffff);
          write_reg(pipc_pkg::CFG_CENTER_Y, 24'h800000);
          write_reg(pipc_pkg::CFG_FLOOR_Z, 24'h800000);
          write_reg(pipc_pkg::CFG_CEIL_Z, 24'h7fffff);
        end
        2: begin
          write_reg(pipc_pkg::CFG_CENTER_X, 24'd0);
          write_reg(pipc_pkg::CFG_CENTER_Y, 24'd0);
        end
        default: begin
          write_reg(pipc_pkg::CFG_CENTER_X, 24'($signed($urandom_range(2000)) - 1000));
          write_reg(pipc_pkg::CFG_CENTER_Y, 24'($signed($urandom_range(2000)) - 1000));
          write_reg(pipc_pkg::CFG_FLOOR_Z, 24'($signed($urandom_range(3000)) - 3000));
          write_reg(pipc_pkg::CFG_CEIL_Z, 24'($urandom_range(3000)));
        end
      endcase
      cfg_valid_i <= 1'b0;
      busy_free = (ph == 3);
      for (int n = 0; n < 235; n++) send_beat(rand_row());
      busy_free = 1'b0;
      drain();
    end

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
